@@ sv/rle_pid_pkg.sv @@
package rle_pid_pkg;

    // Field widths
    localparam int OP_W   = 2;
    localparam int DATA_W = 8;
    localparam int IDX_W  = 16;
    localparam int PIX_W  = 4;
    localparam int CNT_W  = 17;
    localparam int RUN_W  = 8;
    localparam int BIT_W  = 3;
    localparam int PLN_W  = 2;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_NEW  = 2'd2;

    // Register index (word index, paddr[2])
    localparam logic REG_PLANE_LENGTH = 1'b0;

    localparam logic [CNT_W-1:0] PLANE_LENGTH_RST = 17'd64000;

    // Stream command encoding
    localparam int                LITERAL_FLAG = 7;
    localparam logic [RUN_W-1:0]  LITERAL_BIAS = 8'd1;
    localparam logic [RUN_W-1:0]  REPEAT_BIAS  = 8'd3;
    localparam logic [BIT_W-1:0]  BIT_FIRST    = 3'd7;
    localparam logic [PLN_W-1:0]  PLANE_LAST   = 2'd3;

endpackage

@@ sv/rle_planar_image_decoder_unit.sv @@
// Command bytes, new-image, dropped and unknown requests are answered from the request
// itself; a pixel read goes through the registered frame-store read; data bytes expand
// one pixel a cycle: one byte per literal, cmd+3 bytes per repeat, less at image end.
// Throughput: one request at a time; stall stays high until its result is registered.
// Reset (i_rst_n low, synchronous): control state cleared, plane_length back to 64000,
// frame store not cleared and holds whatever was last written.
module rle_planar_image_decoder_unit #(
    parameter int unsigned FRAME_PIXELS = 64000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rle_pid_pkg::OP_W-1:0]        i_operation,
    input  logic [rle_pid_pkg::DATA_W-1:0]      i_data_byte,
    input  logic [rle_pid_pkg::IDX_W-1:0]       i_pixel_index,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rle_pid_pkg::PIX_W-1:0]       o_pixel_value,
    output logic                                o_image_done,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rle_pid_pkg::APB_AW-1:0]      paddr,
    input  logic [rle_pid_pkg::APB_DW-1:0]      pwdata,
    output logic [rle_pid_pkg::APB_DW-1:0]      prdata,
    output logic                                pready
);
    import rle_pid_pkg::*;

    localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_LITERAL,
        PH_REPEAT
    } t_phase;

    // control
    t_state               r_state,     n_state;
    t_phase               r_phase,     n_phase;
    logic [RUN_W-1:0]     r_run,       n_run;
    logic [CNT_W-1:0]     r_pix_cnt,   n_pix_cnt;
    logic [PLN_W-1:0]     r_plane,     n_plane;
    logic                 r_done,      n_done;
    logic [CNT_W-1:0]     r_plane_len, n_plane_len;
    logic                 r_out_valid, n_out_valid;

    // expansion datapath
    logic [DATA_W-1:0]    r_byte,      n_byte;
    logic [BIT_W-1:0]     r_bit_idx,   n_bit_idx;
    logic [RUN_W-1:0]     r_reps,      n_reps;

    // results
    logic [PIX_W-1:0]     r_out_pix,   n_out_pix;
    logic                 r_out_done,  n_out_done;
    logic [PIX_W-1:0]     r_pend_pix,  n_pend_pix;
    logic                 r_pend_done, n_pend_done;
    logic                 r_rd_oob,    n_rd_oob;

    // frame store, one bit lane per plane
    logic [PIX_W-1:0]     r_frame_mem [FRAME_PIXELS];
    logic [PIX_W-1:0]     r_rd_data;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_cfg_wr;
    logic [CNT_W-1:0]     w_limit;
    logic [CNT_W-1:0]     w_cnt_inc;
    logic                 w_plane_end;
    logic                 w_on;
    logic                 w_in_frame;
    logic                 w_last_bit;
    logic                 w_res_valid;
    logic [PIX_W-1:0]     w_res_pix;
    logic                 w_res_done;
    logic [PIX_W-1:0]     w_we;
    logic [PIX_W-1:0]     w_wd;
    logic [ADDR_W-1:0]    w_wr_addr;
    logic [ADDR_W-1:0]    w_rd_addr;
    logic                 w_rd_en;

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_out_pix;
    assign o_image_done  = r_out_done;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PLANE_LENGTH) ? APB_DW'(r_plane_len) : '0;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PLANE_LENGTH);

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // zero plane length behaves as one pixel
    assign w_limit     = (r_plane_len == '0) ? CNT_W'(1) : r_plane_len;
    assign w_cnt_inc   = r_pix_cnt + CNT_W'(1);
    assign w_plane_end = (w_cnt_inc >= w_limit);
    assign w_on        = r_byte[r_bit_idx];
    assign w_in_frame  = (32'(r_pix_cnt) < FRAME_PIXELS);
    assign w_last_bit  = (r_bit_idx == '0);

    // First plane writes the whole entry (its bit, others cleared);
    // later planes only set their own bit where the pixel is on.
    always_comb begin
        w_we = '0;
        w_wd = '0;
        if (r_state == ST_EXPAND && w_in_frame) begin
            if (r_plane == '0) begin
                w_we = '1;
                w_wd = PIX_W'(w_on);
            end else if (w_on) begin
                w_we = PIX_W'(1) << r_plane;
                w_wd = '1;
            end
        end
    end

    assign w_wr_addr = ADDR_W'(r_pix_cnt);
    assign w_rd_addr = ADDR_W'(i_pixel_index);
    assign w_rd_en   = w_accept && (i_operation == OP_READ);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_run       = r_run;
        n_pix_cnt   = r_pix_cnt;
        n_plane     = r_plane;
        n_done      = r_done;
        n_plane_len = r_plane_len;
        n_byte      = r_byte;
        n_bit_idx   = r_bit_idx;
        n_reps      = r_reps;
        n_pend_pix  = r_pend_pix;
        n_pend_done = r_pend_done;
        n_rd_oob    = r_rd_oob;
        n_out_pix   = r_out_pix;
        n_out_done  = r_out_done;
        n_out_valid = r_out_valid && i_out_stall;
        w_res_valid = 1'b0;
        w_res_pix   = '0;
        w_res_done  = r_done;

        if (w_cfg_wr) begin
            n_plane_len = pwdata[CNT_W-1:0];
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_operation)
                        OP_BYTE: begin
                            if (r_done) begin
                                // image complete: byte dropped
                                w_res_valid = 1'b1;
                            end else begin
                                case (r_phase)
                                    PH_LITERAL: begin
                                        n_byte    = i_data_byte;
                                        n_reps    = RUN_W'(1);
                                        n_bit_idx = BIT_FIRST;
                                        n_run     = r_run - RUN_W'(1);
                                        if (r_run <= RUN_W'(1)) begin
                                            n_phase = PH_CMD;
                                        end
                                        n_state   = ST_EXPAND;
                                    end
                                    PH_REPEAT: begin
                                        n_byte    = i_data_byte;
                                        n_reps    = r_run;
                                        n_bit_idx = BIT_FIRST;
                                        n_run     = '0;
                                        n_phase   = PH_CMD;
                                        n_state   = ST_EXPAND;
                                    end
                                    default: begin
                                        if (i_data_byte[LITERAL_FLAG]) begin
                                            n_run   = {1'b0, i_data_byte[LITERAL_FLAG-1:0]}
                                                      + LITERAL_BIAS;
                                            n_phase = PH_LITERAL;
                                        end else begin
                                            n_run   = i_data_byte + REPEAT_BIAS;
                                            n_phase = PH_REPEAT;
                                        end
                                        w_res_valid = 1'b1;
                                    end
                                endcase
                            end
                        end
                        OP_READ: begin
                            n_rd_oob = (32'(i_pixel_index) >= FRAME_PIXELS);
                            n_state  = ST_READ;
                        end
                        OP_NEW: begin
                            n_phase     = PH_CMD;
                            n_run       = '0;
                            n_pix_cnt   = '0;
                            n_plane     = '0;
                            n_done      = 1'b0;
                            w_res_valid = 1'b1;
                            w_res_done  = 1'b0;
                        end
                        default: begin
                            w_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_EXPAND: begin
                // one pixel per cycle, MSB first
                n_bit_idx = r_bit_idx - BIT_W'(1);
                if (w_plane_end) begin
                    n_pix_cnt = '0;
                    if (r_plane == PLANE_LAST) begin
                        n_done = 1'b1;
                    end else begin
                        n_plane = r_plane + PLN_W'(1);
                    end
                end else begin
                    n_pix_cnt = w_cnt_inc;
                end
                if ((w_plane_end && r_plane == PLANE_LAST) ||
                    (w_last_bit && r_reps == RUN_W'(1))) begin
                    // run finished, or image completed and the rest is dropped
                    w_res_valid = 1'b1;
                    w_res_done  = n_done;
                end else if (w_last_bit) begin
                    n_reps = r_reps - RUN_W'(1);
                end
            end
            ST_READ: begin
                w_res_valid = 1'b1;
                w_res_pix   = r_rd_oob ? '0 : r_rd_data;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = r_pend_pix;
                    n_out_done  = r_pend_done;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // result goes straight to the output register, else parks until it frees
        if (w_res_valid) begin
            if (w_out_free) begin
                n_out_valid = 1'b1;
                n_out_pix   = w_res_pix;
                n_out_done  = w_res_done;
                n_state     = ST_IDLE;
            end else begin
                n_pend_pix  = w_res_pix;
                n_pend_done = w_res_done;
                n_state     = ST_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_CMD;
            r_run       <= '0;
            r_pix_cnt   <= '0;
            r_plane     <= '0;
            r_done      <= 1'b0;
            r_plane_len <= PLANE_LENGTH_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_run       <= n_run;
            r_pix_cnt   <= n_pix_cnt;
            r_plane     <= n_plane;
            r_done      <= n_done;
            r_plane_len <= n_plane_len;
            r_out_valid <= n_out_valid;
        end
        r_byte      <= n_byte;
        r_bit_idx   <= n_bit_idx;
        r_reps      <= n_reps;
        r_pend_pix  <= n_pend_pix;
        r_pend_done <= n_pend_done;
        r_rd_oob    <= n_rd_oob;
        r_out_pix   <= n_out_pix;
        r_out_done  <= n_out_done;
    end

    // frame store: per-plane bit write enables, registered read
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PIX_W; k++) begin
            if (w_we[k]) begin
                r_frame_mem[w_wr_addr][k] <= w_wd[k];
            end
        end
        if (w_rd_en) begin
            r_rd_data <= r_frame_mem[w_rd_addr];
        end
    end

    // frame store is only written while a byte is being expanded
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we != '0) |-> (r_state == ST_EXPAND))
        else $error("frame store write outside expansion");

    // done can only be raised by the last pixel of the last plane
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> ($past(r_state) == ST_EXPAND && $past(r_plane) == PLANE_LAST))
        else $error("done set outside last plane expansion");

    // an expansion always has at least one byte left
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXPAND) |-> (r_reps != '0))
        else $error("expansion with empty repeat count");

    // a parked result only exists while the output register is occupied
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_out_valid)
        else $error("parked result with free output register");

    // waiting for a command byte means no run is open
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CMD) |-> (r_run == '0))
        else $error("open run count in command phase");

endmodule
